// ===== design/lmsm_pkg.sv =====
// Shared types and constants for the LED matrix scan multiplexer.
// Used by lmsm_lane and led_matrix_scan_mux; depends on nothing else.
package lmsm_pkg;

  // Default geometry of the attached displays.
  localparam int DISPLAYS_DEF     = 2;
  localparam int COLUMNS_DEF      = 5;
  localparam int ROWS_DEF         = 7;
  localparam int LIT_PER_SCAN_DEF = 4;

  // Widest row count a lane may report.
  localparam int ROWS_MAX = 8;

  // Configuration register indexes.
  localparam logic CFG_BLANK_MASK     = 1'b0;
  localparam logic CFG_PALETTE_SELECT = 1'b1;

  // Input word operation codes.
  typedef enum logic [1:0] {
    OP_SCAN_TICK    = 2'd0,
    OP_WRITE_COLUMN = 2'd1,
    OP_SET_PIXEL    = 2'd2,
    OP_CLEAR_PIXEL  = 2'd3
  } op_t;

  // Frame store write command handed to one display lane.
  typedef struct packed {
    logic       en;
    op_t        op;
    logic [2:0] column;
    logic [2:0] row;
    logic [6:0] bits;
  } wr_cmd_t;

  // What one lane drives after a scan tick.
  typedef struct packed {
    logic [ROWS_MAX-1:0] lit_rows;
    logic [2:0]          lit_column;
    logic                column_on;
    logic                green;
  } lane_status_t;

endpackage

// ===== design/lmsm_lane.sv =====
// One display lane: frame store, scan state and the per-tick row pick.
// Depends on lmsm_pkg.
module lmsm_lane import lmsm_pkg::*; #(
  parameter int COLUMNS      = COLUMNS_DEF,
  parameter int ROWS         = ROWS_DEF,
  parameter int LIT_PER_SCAN = LIT_PER_SCAN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         tick,
  input  wr_cmd_t      cmd,
  input  logic         blank,
  input  logic         palette,
  output lane_status_t status
);

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW = $clog2(ROWS + 2);
  localparam int NW = $clog2(LIT_PER_SCAN + 1);
  localparam logic [PW-1:0] POS_IDLE    = PW'(ROWS);
  localparam logic [PW-1:0] POS_RESTART = PW'(ROWS + 1);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);

  logic [ROWS-1:0] frame_r [COLUMNS];
  logic [CW-1:0]   col_r, col_nxt, lit_col_r, lit_col_nxt, col_c;
  logic [PW-1:0]   pos_r, pos_nxt, pos_start, pos_w;
  logic [ROWS-1:0] pend_r, pend_nxt, data_w, lit_w;
  logic            green_r, green_nxt, col_on_r, col_on_nxt;
  logic [NW-1:0]   nlit_w;
  logic            col_ok, row_ok, wr_hit;

  // Write address checks; out-of-range columns are ignored entirely.
  assign col_ok = ({1'b0, cmd.column} < 4'(COLUMNS));
  assign row_ok = ({1'b0, cmd.row} < 4'(ROWS));
  assign wr_hit = cmd.en && col_ok;

  // Scan step: pick up to LIT_PER_SCAN pending rows from the lowest upward.
  always_comb begin
    col_c       = ({1'b0, col_r} >= (CW+1)'(COLUMNS)) ? '0 : col_r;
    green_nxt   = green_r;
    col_on_nxt  = col_on_r;
    lit_col_nxt = lit_col_r;
    col_nxt     = col_r;
    pos_nxt     = pos_r;
    pend_nxt    = pend_r;
    lit_w       = '0;
    nlit_w      = '0;
    if (pos_r < POS_IDLE) begin
      data_w    = pend_r;
      pos_start = pos_r;
    end else begin
      data_w    = frame_r[col_c];
      pos_start = '0;
    end
    pos_w = pos_start;
    for (int i = 0; i < ROWS; i++) begin
      if (nlit_w < NW'(LIT_PER_SCAN) && PW'(i) >= pos_start && data_w[i]) begin
        lit_w[i]  = 1'b1;
        data_w[i] = 1'b0;
        pos_w     = PW'(i);
        nlit_w    = nlit_w + 1'b1;
      end
    end

    if (tick) begin
      // Frame start: latch the color while idle at column 0.
      if (pos_r == POS_IDLE && col_c == '0) begin
        green_nxt = palette;
      end
      // A new column turns the previous one off, even when blanked.
      if (pos_start == '0) begin
        col_on_nxt  = 1'b0;
        lit_col_nxt = col_c;
      end
      if (!blank) begin
        col_on_nxt = 1'b1;
      end
      pend_nxt = data_w;
      if (data_w == '0) begin
        pos_nxt = POS_IDLE;
        col_nxt = (col_c == COL_LAST) ? '0 : col_c + 1'b1;
      end else begin
        pos_nxt = pos_w;
        col_nxt = col_c;
      end
    end else if (wr_hit) begin
      // Any accepted write restarts the scan at column 0.
      col_nxt = '0;
      pos_nxt = POS_RESTART;
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= COL_LAST;
      pos_r     <= POS_IDLE;
      pend_r    <= '0;
      green_r   <= 1'b1;
      lit_col_r <= COL_LAST;
      col_on_r  <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      pos_r     <= pos_nxt;
      pend_r    <= pend_nxt;
      green_r   <= green_nxt;
      lit_col_r <= lit_col_nxt;
      col_on_r  <= col_on_nxt;
    end
  end

  // Frame store, written a column or a single pixel at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COLUMNS; c++) begin
        frame_r[c] <= '0;
      end
    end else if (wr_hit) begin
      case (cmd.op)
        OP_WRITE_COLUMN: frame_r[cmd.column[CW-1:0]] <= ROWS'({1'b0, cmd.bits});
        OP_SET_PIXEL: begin
          if (row_ok) begin
            frame_r[cmd.column[CW-1:0]][cmd.row[RW-1:0]] <= 1'b1;
          end
        end
        OP_CLEAR_PIXEL: begin
          if (row_ok) begin
            frame_r[cmd.column[CW-1:0]][cmd.row[RW-1:0]] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Lit rows of this tick travel with the updated column state.
  assign status.lit_rows   = ROWS_MAX'(tick ? lit_w : '0);
  assign status.lit_column = 3'(lit_col_nxt);
  assign status.column_on  = col_on_nxt;
  assign status.green      = green_nxt;

endmodule

// ===== design/led_matrix_scan_mux.sv =====
// Column multiplexer for up to two bicolor LED matrices, fed from a frame store.
// Every input word is taken on acceptance, so one word per clock is sustained
// while ready stays high; a scan tick gives its drive pattern in the next
// cycle from the output register, while write words give no result. Ready
// drops only while a result waits in the output register and the sink is not
// taking it. The frame store is held in flip-flops cleared by reset, so no
// clearing pass is needed. Depends on lmsm_pkg and lmsm_lane.
module led_matrix_scan_mux import lmsm_pkg::*; #(
  parameter int DISPLAYS     = DISPLAYS_DEF,
  parameter int COLUMNS      = COLUMNS_DEF,
  parameter int ROWS         = ROWS_DEF,
  parameter int LIT_PER_SCAN = LIT_PER_SCAN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic       in_display_select,
  input  logic [2:0] in_column_number,
  input  logic [2:0] in_row_number,
  input  logic [6:0] in_column_bits,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_columns_n_first,
  output logic [6:0] out_green_rows_first,
  output logic [6:0] out_orange_rows_first,
  output logic [4:0] out_columns_n_second,
  output logic [6:0] out_green_rows_second,
  output logic [6:0] out_orange_rows_second
);

  logic [1:0]   blank_mask_r, palette_r;
  logic         accept, tick;
  op_t          op;
  logic [DISPLAYS-1:0] lane_blank, lane_palette;
  lane_status_t lane_st [DISPLAYS];
  lane_status_t st_first, st_second;
  logic         out_valid_r;
  logic [4:0]   cols_first_r, cols_second_r;
  logic [6:0]   green_first_r, orange_first_r, green_second_r, orange_second_r;

  // Column drive: the lit column's bit goes low when it is enabled.
  function automatic logic [4:0] col_drive(input lane_status_t st);
    logic [7:0] onehot;
    onehot = 8'd1 << st.lit_column;
    return st.column_on ? ~onehot[4:0] : 5'h1F;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_mask_r <= '0;
      palette_r    <= '0;
    end else if (cfg_write_en) begin
      if (cfg_index == CFG_BLANK_MASK) begin
        blank_mask_r <= cfg_data;
      end else begin
        palette_r <= cfg_data;
      end
    end
  end

  // Input handshake.
  assign op       = op_t'(in_operation);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (op == OP_SCAN_TICK);

  // One lane per display.
  for (genvar d = 0; d < DISPLAYS; d++) begin : g_lane
    wr_cmd_t cmd;

    if (d < 2) begin : g_cfg
      assign lane_blank[d]   = blank_mask_r[d];
      assign lane_palette[d] = palette_r[d];
    end else begin : g_nocfg
      assign lane_blank[d]   = 1'b0;
      assign lane_palette[d] = 1'b0;
    end

    assign cmd.en     = accept && (op != OP_SCAN_TICK) && (int'(in_display_select) == d);
    assign cmd.op     = op;
    assign cmd.column = in_column_number;
    assign cmd.row    = in_row_number;
    assign cmd.bits   = in_column_bits;

    lmsm_lane #(
      .COLUMNS      (COLUMNS),
      .ROWS         (ROWS),
      .LIT_PER_SCAN (LIT_PER_SCAN)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick    (tick),
      .cmd     (cmd),
      .blank   (lane_blank[d]),
      .palette (lane_palette[d]),
      .status  (lane_st[d])
    );
  end

  // An absent second display stays dark with all columns off.
  assign st_first = lane_st[0];
  if (DISPLAYS > 1) begin : g_second
    assign st_second = lane_st[1];
  end else begin : g_no_second
    assign st_second = '0;
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      cols_first_r    <= col_drive(st_first);
      green_first_r   <= st_first.green ? st_first.lit_rows[6:0] : 7'd0;
      orange_first_r  <= st_first.green ? 7'd0 : st_first.lit_rows[6:0];
      cols_second_r   <= col_drive(st_second);
      green_second_r  <= st_second.green ? st_second.lit_rows[6:0] : 7'd0;
      orange_second_r <= st_second.green ? 7'd0 : st_second.lit_rows[6:0];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_columns_n_first    = cols_first_r;
  assign out_green_rows_first   = green_first_r;
  assign out_orange_rows_first  = orange_first_r;
  assign out_columns_n_second   = cols_second_r;
  assign out_green_rows_second  = green_second_r;
  assign out_orange_rows_second = orange_second_r;

  // A scan tick always leaves a word in the output register.
  a_tick_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid)
    else $error("scan tick produced no output word");

  // A write word never leaves a result behind.
  a_write_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !tick) |=> !out_valid)
    else $error("write word produced an output word");

  // At most one column of each display is enabled.
  a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(~out_columns_n_first) <= 1 &&
                   $countones(~out_columns_n_second) <= 1))
    else $error("more than one column enabled");

  // Only one color is driven per display.
  a_one_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_green_rows_first == 7'd0 || out_orange_rows_first == 7'd0) &&
                   (out_green_rows_second == 7'd0 || out_orange_rows_second == 7'd0)))
    else $error("both colors driven on one display");

endmodule
